@@ rtl/core/msp_pkg.sv @@
// shared types and constants for the msp v1 frame receiver
// no dependencies
`default_nettype none

package msp_pkg;

    localparam int BYTE_W              = 8;
    localparam int MAX_PAYLOAD_DEFAULT = 64;
    localparam int LENGTH_W            = 7;
    localparam int BYTE_INDEX_W        = 6;
    localparam int M_TDATA_W           = 32;
    localparam int APB_ADDR_W          = 3;
    localparam int APB_DATA_W          = 32;

    localparam logic [BYTE_W-1:0] TIMEOUT_RESET = 8'd10;

    localparam logic [BYTE_W-1:0] CH_START  = 8'h24;
    localparam logic [BYTE_W-1:0] CH_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] CH_TO_DEV = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_TO_APP = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_ERROR  = 8'h21;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic REG_TIMEOUT = 1'b0;

    typedef struct packed {
        logic              dir;
        logic              err;
        logic [BYTE_W-1:0] cmd;
        logic [BYTE_W-1:0] len;
    } frame_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic wr_slot;
        logic rd_slot;
    } queue_status_t;

endpackage

`default_nettype wire

@@ rtl/core/msp_v1_frame_receiver_unit.sv @@
// top level of the msp v1 frame receiver: apb register, parser, queue, replay
// depends on msp_pkg, msp_ram, msp_queue, msp_front, msp_back
`default_nettype none

// Takes one received byte or timer tick per cycle on the s_ stream and parses
// msp v1 frames; a frame with a good checksum is replayed on the m_ stream as
// one item per payload byte (one item for a zero-length frame). A payload item
// passes through a fetch state, for the registered read of the payload ram, and
// then a send state that presents it and holds it while m_tready is low.
// A frame's first item is offered once its descriptor is registered in the
// queue and the replay has gone from idle through fetch to send (idle to send
// for a zero-length frame); each frame's replay starts from the idle state.
// The payload ram holds two frame banks, so the next frame is received while
// the previous one replays; s_tready drops only while both banks hold frames
// not yet fully delivered. The timeout register sits at byte address 0 of the
// apb port and resets to 10 ticks.
module msp_v1_frame_receiver_unit #(
    parameter int MAX_PAYLOAD = msp_pkg::MAX_PAYLOAD_DEFAULT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,  // rx_byte
    input  wire logic                               s_tuser,  // kind
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // direction, error_frame, command, length, payload_byte, byte_index, pad
    output logic      [msp_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                    m_tuser,  // has_payload
    output logic                                    m_tlast,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [msp_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [msp_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [msp_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                    pready
);

    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic [msp_pkg::BYTE_W-1:0] timeout_reg;
    logic                       s_accept;
    logic                       ram_wr_en;
    logic [IDX_W:0]             ram_wr_addr;
    logic [msp_pkg::BYTE_W-1:0] ram_wr_data;
    logic                       ram_rd_en;
    logic [IDX_W:0]             ram_rd_addr;
    logic [msp_pkg::BYTE_W-1:0] ram_rd_data;
    logic                       q_push;
    logic                       q_pop;
    msp_pkg::frame_desc_t       push_desc;
    msp_pkg::frame_desc_t       head_desc;
    msp_pkg::queue_status_t     q_status;

    logic                                direction;
    logic                                error_frame;
    logic [msp_pkg::BYTE_W-1:0]          command;
    logic [msp_pkg::LENGTH_W-1:0]        length;
    logic [msp_pkg::BYTE_W-1:0]          payload_byte;
    logic [msp_pkg::BYTE_INDEX_W-1:0]    byte_index;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= msp_pkg::TIMEOUT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == msp_pkg::REG_TIMEOUT) begin
            timeout_reg <= pwdata[msp_pkg::BYTE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == msp_pkg::REG_TIMEOUT)
                  ? msp_pkg::APB_DATA_W'(timeout_reg) : '0;

    assign s_tready = !q_status.full;
    assign s_accept = s_tvalid && s_tready;

    msp_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (s_accept),
        .kind         (s_tuser),
        .rx_byte      (s_tdata),
        .timeout_ticks(timeout_reg),
        .wr_slot      (q_status.wr_slot),
        .ram_wr_en    (ram_wr_en),
        .ram_wr_addr  (ram_wr_addr),
        .ram_wr_data  (ram_wr_data),
        .push         (q_push),
        .push_desc    (push_desc)
    );

    msp_ram #(
        .WIDTH(msp_pkg::BYTE_W),
        .DEPTH(2 ** (IDX_W + 1))
    ) u_payload_ram (
        .aclk   (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    msp_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_desc(push_desc),
        .pop      (q_pop),
        .head_desc(head_desc),
        .status   (q_status)
    );

    msp_back #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_desc   (head_desc),
        .q_status    (q_status),
        .pop         (q_pop),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .res_valid   (m_tvalid),
        .res_ready   (m_tready),
        .direction   (direction),
        .error_frame (error_frame),
        .command     (command),
        .length      (length),
        .has_payload (m_tuser),
        .payload_byte(payload_byte),
        .byte_index  (byte_index),
        .last        (m_tlast)
    );

    assign m_tdata = {1'b0, byte_index, payload_byte, length, command,
                      error_frame, direction};

`ifndef SYNTHESIS
    a_bank_split: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && ram_rd_en) |-> (ram_wr_addr[IDX_W] != ram_rd_addr[IDX_W]))
        else $error("payload write hits the bank being replayed");

    a_valid_has_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !q_status.empty)
        else $error("result presented with no queued frame");

    a_pop_frees_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast && !q_push) |=> !q_status.full)
        else $error("frame slot not released after last item");
`endif

endmodule

`default_nettype wire

@@ rtl/core/msp_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/msp_queue.sv @@
// two-slot frame descriptor queue; slot number doubles as payload bank
// depends on msp_pkg
`default_nettype none

module msp_queue (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  push,
    input  wire msp_pkg::frame_desc_t  push_desc,
    input  wire logic                  pop,
    output msp_pkg::frame_desc_t       head_desc,
    output msp_pkg::queue_status_t     status
);

    msp_pkg::frame_desc_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    assign head_desc      = slot_reg[rd_ptr_reg];
    assign status.full    = (count_reg == 2'd2);
    assign status.empty   = (count_reg == 2'd0);
    assign status.wr_slot = wr_ptr_reg;
    assign status.rd_slot = rd_ptr_reg;

endmodule

`default_nettype wire

@@ rtl/core/msp_front.sv @@
// front end: frame parser, timeout, payload write and descriptor push
// depends on msp_pkg
`default_nettype none

module msp_front #(
    parameter int MAX_PAYLOAD = msp_pkg::MAX_PAYLOAD_DEFAULT,
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
    localparam int CNT_W = $clog2(MAX_PAYLOAD + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          item_valid,
    input  wire logic                          kind,
    input  wire logic [msp_pkg::BYTE_W-1:0]    rx_byte,
    input  wire logic [msp_pkg::BYTE_W-1:0]    timeout_ticks,
    input  wire logic                          wr_slot,
    output logic                               ram_wr_en,
    output logic      [IDX_W:0]                ram_wr_addr,
    output logic      [msp_pkg::BYTE_W-1:0]    ram_wr_data,
    output logic                               push,
    output msp_pkg::frame_desc_t               push_desc
);

    typedef enum logic [6:0] {
        ST_HUNT = 7'b0000001,
        ST_M    = 7'b0000010,
        ST_MARK = 7'b0000100,
        ST_LEN  = 7'b0001000,
        ST_CMD  = 7'b0010000,
        ST_DATA = 7'b0100000,
        ST_CS   = 7'b1000000
    } front_state_t;

    front_state_t state_reg, state_next, cur_state;

    logic                       dir_reg, dir_next;
    logic                       err_reg, err_next;
    logic [msp_pkg::BYTE_W-1:0] cmd_reg, cmd_next;
    logic [msp_pkg::BYTE_W-1:0] len_reg, len_next;
    logic [msp_pkg::BYTE_W-1:0] xor_reg, xor_next;
    logic [msp_pkg::BYTE_W-1:0] elapsed_reg, elapsed_next;
    logic [msp_pkg::BYTE_W-1:0] elapsed_inc;
    logic [CNT_W-1:0]           fill_reg, fill_next;
    logic [CNT_W-1:0]           fill_inc;

    assign fill_inc    = fill_reg + CNT_W'(1);
    assign elapsed_inc = (elapsed_reg != 8'hFF) ? elapsed_reg + 8'd1 : elapsed_reg;

    always_comb begin
        cur_state = state_reg;
        if (state_reg != ST_HUNT && elapsed_reg > timeout_ticks) begin
            cur_state = ST_HUNT;
        end
    end

    always_comb begin
        state_next   = state_reg;
        dir_next     = dir_reg;
        err_next     = err_reg;
        cmd_next     = cmd_reg;
        len_next     = len_reg;
        xor_next     = xor_reg;
        elapsed_next = elapsed_reg;
        fill_next    = fill_reg;
        ram_wr_en    = 1'b0;
        push         = 1'b0;
        if (item_valid) begin
            if (kind == msp_pkg::KIND_TICK) begin
                if (state_reg != ST_HUNT) begin
                    elapsed_next = elapsed_inc;
                    if (elapsed_inc > timeout_ticks) begin
                        state_next = ST_HUNT;
                    end
                end
            end else begin
                state_next = cur_state;
                case (cur_state)
                    ST_HUNT: begin
                        if (rx_byte == msp_pkg::CH_START) begin
                            dir_next     = 1'b0;
                            err_next     = 1'b0;
                            cmd_next     = '0;
                            len_next     = '0;
                            fill_next    = '0;
                            xor_next     = '0;
                            elapsed_next = '0;
                            state_next   = ST_M;
                        end
                    end
                    ST_M: begin
                        state_next = (rx_byte == msp_pkg::CH_M) ? ST_MARK : ST_HUNT;
                    end
                    ST_MARK: begin
                        if (rx_byte == msp_pkg::CH_TO_DEV) begin
                            dir_next   = 1'b0;
                            err_next   = 1'b0;
                            state_next = ST_LEN;
                        end else if (rx_byte == msp_pkg::CH_TO_APP) begin
                            dir_next   = 1'b1;
                            err_next   = 1'b0;
                            state_next = ST_LEN;
                        end else if (rx_byte == msp_pkg::CH_ERROR) begin
                            err_next   = 1'b1;
                            state_next = ST_LEN;
                        end else begin
                            state_next = ST_HUNT;
                        end
                    end
                    ST_LEN: begin
                        len_next   = rx_byte;
                        xor_next   = rx_byte;
                        state_next = ST_CMD;
                    end
                    ST_CMD: begin
                        cmd_next   = rx_byte;
                        xor_next   = xor_reg ^ rx_byte;
                        fill_next  = '0;
                        state_next = (len_reg == '0) ? ST_CS : ST_DATA;
                    end
                    ST_DATA: begin
                        ram_wr_en = 1'b1;
                        fill_next = fill_inc;
                        xor_next  = xor_reg ^ rx_byte;
                        if (fill_inc >= CNT_W'(MAX_PAYLOAD)) begin
                            state_next = ST_HUNT;
                        end
                        if (msp_pkg::BYTE_W'(fill_inc) == len_reg) begin
                            state_next = ST_CS;
                        end
                    end
                    ST_CS: begin
                        state_next = ST_HUNT;
                        push       = (xor_reg == rx_byte);
                    end
                    default: begin
                        state_next = ST_HUNT;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_HUNT;
            dir_reg     <= 1'b0;
            err_reg     <= 1'b0;
            cmd_reg     <= '0;
            len_reg     <= '0;
            xor_reg     <= '0;
            elapsed_reg <= '0;
            fill_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            dir_reg     <= dir_next;
            err_reg     <= err_next;
            cmd_reg     <= cmd_next;
            len_reg     <= len_next;
            xor_reg     <= xor_next;
            elapsed_reg <= elapsed_next;
            fill_reg    <= fill_next;
        end
    end

    assign ram_wr_addr   = {wr_slot, fill_reg[IDX_W-1:0]};
    assign ram_wr_data   = rx_byte;
    assign push_desc.dir = dir_reg;
    assign push_desc.err = err_reg;
    assign push_desc.cmd = cmd_reg;
    assign push_desc.len = len_reg;

endmodule

`default_nettype wire

@@ rtl/core/msp_back.sv @@
// back end: replays a queued frame as one result per payload byte (one result for a zero-length frame)
// depends on msp_pkg
`default_nettype none

module msp_back #(
    parameter int MAX_PAYLOAD = msp_pkg::MAX_PAYLOAD_DEFAULT,
    localparam int IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire msp_pkg::frame_desc_t              head_desc,
    input  wire msp_pkg::queue_status_t            q_status,
    output logic                                   pop,
    output logic                                   ram_rd_en,
    output logic      [IDX_W:0]                    ram_rd_addr,
    input  wire logic [msp_pkg::BYTE_W-1:0]        ram_rd_data,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output logic                                   direction,
    output logic                                   error_frame,
    output logic      [msp_pkg::BYTE_W-1:0]        command,
    output logic      [msp_pkg::LENGTH_W-1:0]      length,
    output logic                                   has_payload,
    output logic      [msp_pkg::BYTE_W-1:0]        payload_byte,
    output logic      [msp_pkg::BYTE_INDEX_W-1:0]  byte_index,
    output logic                                   last
);

    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_FETCH = 3'b010,
        B_SEND  = 3'b100
    } back_state_t;

    back_state_t      state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    assign has_payload = (head_desc.len != '0);
    assign last = has_payload
                ? ((msp_pkg::BYTE_W'(idx_reg) + 8'd1) == head_desc.len) : 1'b1;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        ram_rd_en  = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (!q_status.empty) begin
                    idx_next   = '0;
                    state_next = has_payload ? B_FETCH : B_SEND;
                end
            end
            B_FETCH: begin
                ram_rd_en  = 1'b1;
                state_next = B_SEND;
            end
            B_SEND: begin
                if (res_ready) begin
                    if (last) begin
                        pop        = 1'b1;
                        state_next = B_IDLE;
                    end else begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = B_FETCH;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign ram_rd_addr  = {q_status.rd_slot, idx_reg};
    assign res_valid    = (state_reg == B_SEND);
    assign direction    = head_desc.dir;
    assign error_frame  = head_desc.err;
    assign command      = head_desc.cmd;
    assign length       = msp_pkg::LENGTH_W'(head_desc.len);
    assign payload_byte = has_payload ? ram_rd_data : '0;
    assign byte_index   = has_payload ? msp_pkg::BYTE_INDEX_W'(idx_reg) : '0;

endmodule

`default_nettype wire
